@@ hw/rtl/random_square_placer_defines.svh @@
// Assertion macros used by the checker file of the square placer.
`ifndef RANDOM_SQUARE_PLACER_DEFINES_SVH
`define RANDOM_SQUARE_PLACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rsp_pkg.sv @@
package rsp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // field widths
    localparam int RAND_W     = 31;
    localparam int COORD_W    = 12;
    localparam int MARGIN_W   = 11;
    localparam int SQ_CNT_W   = 7;
    localparam int BUDGET_W   = 16;
    localparam int NUM_OUT_W  = 6;

    // signed width for region bounds after margin and side are applied
    localparam int GEO_W      = 14;

    // register reset values
    localparam logic [COORD_W-1:0]  RST_REGION_RIGHT  = 12'd1920;
    localparam logic [COORD_W-1:0]  RST_REGION_BOTTOM = 12'd1080;
    localparam logic [COORD_W-1:0]  RST_SIDE_LENGTH   = 12'd64;
    localparam logic [BUDGET_W-1:0] RST_TRIAL_BUDGET  = 16'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_LEFT   = 3'd0,
        CFG_REGION_TOP    = 3'd1,
        CFG_REGION_RIGHT  = 3'd2,
        CFG_REGION_BOTTOM = 3'd3,
        CFG_EDGE_MARGIN   = 3'd4,
        CFG_SIDE_LENGTH   = 3'd5,
        CFG_SQUARE_COUNT  = 3'd6,
        CFG_TRIAL_BUDGET  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DRAW  = 1'b1
    } t_op;

    // sequencer to scan unit
    typedef struct packed {
        logic start;
        logic wr_en;
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_sts;

endpackage

@@ hw/rtl/rsp_mod_unit.sv @@
module rsp_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rsp_pkg::RAND_W-1:0]    i_dividend,
    input  logic [rsp_pkg::COORD_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [rsp_pkg::COORD_W-1:0]   o_rem
);
    import rsp_pkg::*;

    localparam int CNT_W = $clog2(RAND_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RAND_W-1:0] r_dvd;
    logic [COORD_W-1:0] r_div;
    logic [COORD_W-1:0] r_rem;

    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               fits;
    logic [COORD_W-1:0] n_rem;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {r_rem, r_dvd[RAND_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[RAND_W-2:0], 1'b0};
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(RAND_W - 1);
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hw/rtl/rsp_hit_scan.sv @@
module rsp_hit_scan #(
    parameter  int MAX_SQUARES = 64,
    parameter  int COORD_BITS  = 12,
    localparam int TOT_W  = $clog2(MAX_SQUARES + 1),
    localparam int ADDR_W = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1,
    localparam int ENT_W  = 2 * COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsp_pkg::t_scan_ctl          i_ctl,
    input  logic [TOT_W-1:0]            i_total,
    input  logic [rsp_pkg::COORD_W-1:0] i_cx,
    input  logic [rsp_pkg::COORD_W-1:0] i_cy,
    input  logic [rsp_pkg::COORD_W-1:0] i_side,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [ENT_W-1:0]            i_wr_data,
    output rsp_pkg::t_scan_sts          o_sts
);
    import rsp_pkg::*;

    // compare width holds a stored corner plus a side
    localparam int CW = ((COORD_BITS > COORD_W) ? COORD_BITS : COORD_W) + 1;

    logic [ENT_W-1:0] r_mem [MAX_SQUARES];
    logic [ENT_W-1:0] r_rd_data;
    logic [TOT_W-1:0] r_idx;
    logic             r_active;
    logic             r_rd_valid;
    logic             r_hit;
    logic             r_done;

    logic [ADDR_W-1:0] rd_addr;
    logic              issue;
    logic [CW-1:0]     px, py, ax, ay, sd;
    logic              overlap;

    assign rd_addr = r_idx[ADDR_W-1:0];
    assign issue   = r_active && (r_idx < i_total);

    // corner store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // box overlap of candidate against one stored corner
    always_comb begin
        px = CW'(r_rd_data[COORD_BITS-1:0]);
        py = CW'(r_rd_data[ENT_W-1:COORD_BITS]);
        ax = CW'(i_cx);
        ay = CW'(i_cy);
        sd = CW'(i_side);
        overlap = (ax < px + sd) && (px < ax + sd) && (ay < py + sd) && (py < ay + sd);
    end

    // walk placed entries, one read issued per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_done     <= 1'b0;
        end else if (i_ctl.start) begin
            r_active   <= 1'b1;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_active) begin
                r_rd_valid <= issue;
                if (issue) begin
                    r_idx <= r_idx + TOT_W'(1);
                end
                if (r_rd_valid && overlap) begin
                    r_hit <= 1'b1;
                end
                if (!issue && !r_rd_valid) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.hit  = r_hit;

endmodule

@@ hw/rtl/random_square_placer.sv @@
// Start beat, idle draw or failing draw: through S_GEOM to failure result or idle again.
// Draw beat: S_GEOM, S_MODC, S_MODR, S_SCAN in turn, then any result and next accept; time
// set by the bit-serial remainder unit (31 steps per axis, shared by both axes) and the
// corner scan of squares placed so far, one entry per cycle; busy stays high until done.
// Results appear on a one-cycle strobe; the receiver cannot stall.
// Reset (synchronous, active low) restores register defaults and closes any run.
module random_square_placer #(
    parameter int MAX_SQUARES = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [rsp_pkg::RAND_W-1:0]      i_rand_col,
    input  logic [rsp_pkg::RAND_W-1:0]      i_rand_row,
    output logic                            o_strobe,
    output logic [rsp_pkg::COORD_W-1:0]     o_square_col,
    output logic [rsp_pkg::COORD_W-1:0]     o_square_row,
    output logic [rsp_pkg::NUM_OUT_W-1:0]   o_square_number,
    output logic                            o_may_overlap,
    output logic                            o_status,
    output logic                            o_last
);
    import rsp_pkg::*;

    localparam int TOT_W   = $clog2(MAX_SQUARES + 1);
    localparam int ADDR_W  = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
    localparam int ENT_W   = 2 * COORD_BITS;
    localparam int CW      = ((COORD_BITS > COORD_W) ? COORD_BITS : COORD_W) + 1;
    localparam int CNT_W   = (TOT_W > SQ_CNT_W) ? TOT_W : SQ_CNT_W;
    localparam int NUM_W   = (TOT_W > NUM_OUT_W) ? TOT_W : NUM_OUT_W;
    localparam int BUD_X_W = BUDGET_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEOM,
        S_MODC,
        S_MODR,
        S_SCAN
    } t_state;

    // configuration registers
    logic [COORD_W-1:0]  r_left, r_top, r_right, r_bottom, r_side;
    logic [MARGIN_W-1:0] r_margin;
    logic [SQ_CNT_W-1:0] r_sqcnt;
    logic [BUDGET_W-1:0] r_budget;

    // sequencer state
    t_state              r_state;
    t_op                 r_op;
    logic [RAND_W-1:0]   r_rand_col, r_rand_row;
    logic [COORD_W-1:0]  r_xmin, r_ymin, r_yspan, r_cx, r_cy;
    logic [TOT_W-1:0]    r_count;
    logic                r_run;
    logic [TOT_W-1:0]    r_placed;
    logic [BUDGET_W-1:0] r_tries;

    // result registers
    logic                 r_strobe;
    logic [COORD_W-1:0]   r_out_col, r_out_row;
    logic [NUM_OUT_W-1:0] r_out_num;
    logic                 r_out_ovl, r_out_status, r_out_last;

    // geometry
    logic signed [GEO_W-1:0] g_xl, g_yt, g_xmax, g_ymax, g_xspan, g_yspan;
    logic [CNT_W-1:0]        g_sq, g_cnt;
    logic                    g_ok;

    // remainder unit
    logic                mod_start, mod_done;
    logic [RAND_W-1:0]   mod_dvd;
    logic [COORD_W-1:0]  mod_div, mod_rem;
    logic [COORD_W:0]    cx_sum, cy_sum;

    // scan unit
    t_scan_ctl           scan_ctl;
    t_scan_sts           scan_sts;
    logic [CW-1:0]       cx_ext, cy_ext;
    logic [ENT_W-1:0]    wr_entry;

    // commit decision
    logic [BUD_X_W-1:0]  tries_nx, bud_eff;
    logic                commit, room, last_sq;
    logic [TOT_W-1:0]    placed_nx;
    logic [NUM_W-1:0]    num_ext;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= RST_REGION_RIGHT;
            r_bottom <= RST_REGION_BOTTOM;
            r_margin <= '0;
            r_side   <= RST_SIDE_LENGTH;
            r_sqcnt  <= '0;
            r_budget <= RST_TRIAL_BUDGET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REGION_LEFT:   r_left   <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_TOP:    r_top    <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_RIGHT:  r_right  <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_BOTTOM: r_bottom <= i_cfg_data[COORD_W-1:0];
                CFG_EDGE_MARGIN:   r_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_SIDE_LENGTH:   r_side   <= i_cfg_data[COORD_W-1:0];
                CFG_SQUARE_COUNT:  r_sqcnt  <= i_cfg_data[SQ_CNT_W-1:0];
                CFG_TRIAL_BUDGET:  r_budget <= i_cfg_data[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    // corner range after margin and side; spans are inclusive
    always_comb begin
        g_xl    = signed'(GEO_W'(r_left)) + signed'(GEO_W'(r_margin));
        g_yt    = signed'(GEO_W'(r_top)) + signed'(GEO_W'(r_margin));
        g_xmax  = signed'(GEO_W'(r_right)) - signed'(GEO_W'(r_margin))
                  - signed'(GEO_W'(r_side));
        g_ymax  = signed'(GEO_W'(r_bottom)) - signed'(GEO_W'(r_margin))
                  - signed'(GEO_W'(r_side));
        g_xspan = g_xmax - g_xl + signed'(GEO_W'(1));
        g_yspan = g_ymax - g_yt + signed'(GEO_W'(1));
        g_sq    = CNT_W'(r_sqcnt);
        g_cnt   = (g_sq > CNT_W'(MAX_SQUARES)) ? CNT_W'(MAX_SQUARES) : g_sq;
        g_ok    = (g_cnt != '0) && (r_side != '0) && !(g_xl > g_xmax) && !(g_yt > g_ymax);
    end

    // remainder unit runs column first, then row
    always_comb begin
        mod_start = ((r_state == S_GEOM) && (r_op == OP_DRAW) && r_run && g_ok)
                    || ((r_state == S_MODC) && mod_done);
        mod_dvd   = (r_state == S_GEOM) ? r_rand_col : r_rand_row;
        mod_div   = (r_state == S_GEOM) ? g_xspan[COORD_W-1:0] : r_yspan;
        cx_sum    = (COORD_W+1)'(r_xmin) + (COORD_W+1)'(mod_rem);
        cy_sum    = (COORD_W+1)'(r_ymin) + (COORD_W+1)'(mod_rem);
    end

    // commit when clear or when the budget is spent
    always_comb begin
        tries_nx  = BUD_X_W'(r_tries) + BUD_X_W'(1);
        bud_eff   = (r_budget == '0) ? BUD_X_W'(1) : BUD_X_W'(r_budget);
        commit    = !scan_sts.hit || (tries_nx >= bud_eff);
        room      = (r_placed < TOT_W'(MAX_SQUARES));
        placed_nx = room ? (r_placed + TOT_W'(1)) : r_placed;
        last_sq   = (placed_nx >= r_count);
        num_ext   = NUM_W'(r_placed);
        cx_ext    = CW'(r_cx);
        cy_ext    = CW'(r_cy);
        wr_entry  = {cy_ext[COORD_BITS-1:0], cx_ext[COORD_BITS-1:0]};
        scan_ctl.start = (r_state == S_MODR) && mod_done;
        scan_ctl.wr_en = (r_state == S_SCAN) && scan_sts.done && commit && room;
    end

    rsp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (mod_div),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    rsp_hit_scan #(
        .MAX_SQUARES (MAX_SQUARES),
        .COORD_BITS  (COORD_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_total   (r_placed),
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_side    (r_side),
        .i_wr_addr (r_placed[ADDR_W-1:0]),
        .i_wr_data (wr_entry),
        .o_sts     (scan_sts)
    );

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_START;
            r_rand_col   <= '0;
            r_rand_row   <= '0;
            r_xmin       <= '0;
            r_ymin       <= '0;
            r_yspan      <= '0;
            r_count      <= '0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_run        <= 1'b0;
            r_placed     <= '0;
            r_tries      <= '0;
            r_strobe     <= 1'b0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_num    <= '0;
            r_out_ovl    <= 1'b0;
            r_out_status <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op       <= t_op'(i_operation);
                        r_rand_col <= i_rand_col;
                        r_rand_row <= i_rand_row;
                        r_state    <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    r_xmin  <= g_xl[COORD_W-1:0];
                    r_ymin  <= g_yt[COORD_W-1:0];
                    r_yspan <= g_yspan[COORD_W-1:0];
                    r_count <= g_cnt[TOT_W-1:0];
                    r_state <= S_IDLE;
                    if ((r_op == OP_START || r_run) && !g_ok) begin
                        // failure beat closes the run
                        r_strobe     <= 1'b1;
                        r_out_col    <= '0;
                        r_out_row    <= '0;
                        r_out_num    <= '0;
                        r_out_ovl    <= 1'b0;
                        r_out_status <= 1'b1;
                        r_out_last   <= 1'b1;
                        r_run        <= 1'b0;
                    end else if (r_op == OP_START) begin
                        r_run    <= 1'b1;
                        r_placed <= '0;
                        r_tries  <= '0;
                    end else if (r_run) begin
                        r_state <= S_MODC;
                    end
                end
                S_MODC: begin
                    if (mod_done) begin
                        r_cx    <= cx_sum[COORD_W-1:0];
                        r_state <= S_MODR;
                    end
                end
                S_MODR: begin
                    if (mod_done) begin
                        r_cy    <= cy_sum[COORD_W-1:0];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_sts.done) begin
                        r_state <= S_IDLE;
                        if (commit) begin
                            r_placed     <= placed_nx;
                            r_tries      <= '0;
                            r_strobe     <= 1'b1;
                            r_out_col    <= r_cx;
                            r_out_row    <= r_cy;
                            r_out_num    <= num_ext[NUM_OUT_W-1:0];
                            r_out_ovl    <= scan_sts.hit;
                            r_out_status <= 1'b0;
                            r_out_last   <= last_sq;
                            if (last_sq) begin
                                r_run <= 1'b0;
                            end
                        end else begin
                            r_tries <= tries_nx[BUDGET_W-1:0];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_square_col    = r_out_col;
    assign o_square_row    = r_out_row;
    assign o_square_number = r_out_num;
    assign o_may_overlap   = r_out_ovl;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule

@@ hw/rtl/rsp_checker.sv @@
`include "random_square_placer_defines.svh"

module rsp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_strobe,
    input logic [rsp_pkg::COORD_W-1:0]     o_square_col,
    input logic [rsp_pkg::COORD_W-1:0]     o_square_row,
    input logic [rsp_pkg::NUM_OUT_W-1:0]   o_square_number,
    input logic                            o_may_overlap,
    input logic                            o_status,
    input logic                            o_last
);
    import rsp_pkg::*;

    // failure beat carries nothing and closes the run
    `RSP_ASSERT_NOW(a_fail_beat, i_clk, i_rst_n, o_strobe && o_status, o_last && !o_may_overlap && o_square_col == '0 && o_square_row == '0 && o_square_number == '0, "failure beat not clean")

    // an accepted beat keeps the block busy the next cycle
    `RSP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "not busy after accept")

    // results leave only once the block is idle again
    `RSP_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result while busy")

    // at most one result per beat, never back to back
    `RSP_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "back-to-back results")

endmodule

bind random_square_placer rsp_checker u_rsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_square_col    (o_square_col),
    .o_square_row    (o_square_row),
    .o_square_number (o_square_number),
    .o_may_overlap   (o_may_overlap),
    .o_status        (o_status),
    .o_last          (o_last)
);
